// ===== src/bdq_pkg.sv =====
// Shared types and constants for the bounded double-ended queue.
// Holds the command and error codes, the request and result transfer structs,
// and the shift-cell operation codes used by the cell chain and the top level.
package bdq_pkg;

    localparam int unsigned WORD_BITS  = 64;
    localparam int unsigned COUNT_BITS = 5;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REVERSE    = 3'd4,
        CMD_PEEK       = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        CHAIN_HOLD       = 2'd0,
        CHAIN_SHIFT_UP   = 2'd1,
        CHAIN_SHIFT_DOWN = 2'd2,
        CHAIN_LOAD_AT    = 2'd3
    } chain_op_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_UP   = 2'd1,
        CELL_SHIFT_DOWN = 2'd2,
        CELL_LOAD       = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic [2:0]           cmd;
        logic [WORD_BITS-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]  front_value;
        logic [WORD_BITS-1:0]  back_value;
        logic [COUNT_BITS-1:0] entry_count;
        logic                  is_empty;
        logic                  is_full;
        logic [1:0]            error_code;
    } out_item_t;

endpackage

// ===== src/bdq_cell.sv =====
// One storage cell of the shift chain: a single word register.
// Takes its lower or upper neighbor's word, a new word, or holds.
// Depends on bdq_pkg for the cell operation codes.
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int unsigned WORD_WIDTH = 64
)
(
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic [WORD_WIDTH-1:0] from_lower,
    input  logic [WORD_WIDTH-1:0] from_upper,
    input  logic [WORD_WIDTH-1:0] load_word,
    output logic [WORD_WIDTH-1:0] word
);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;

    always_comb
    begin
        unique case (op)
            CELL_SHIFT_UP:   word_next = from_lower;
            CELL_SHIFT_DOWN: word_next = from_upper;
            CELL_LOAD:       word_next = load_word;
            default:         word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== src/bdq_chain.sv =====
// A row of DEPTH shift cells with a shared operation and a decoded load slot.
// Cell zero and the top cell are visible at fixed places as the two ends.
// Depends on bdq_pkg and bdq_cell.
module bdq_chain
    import bdq_pkg::*;
#(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned WORD_WIDTH = 64,
    parameter int unsigned IDX_W      = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  chain_op_t             op,
    input  logic [IDX_W-1:0]      load_index,
    input  logic [WORD_WIDTH-1:0] value,
    output logic [WORD_WIDTH-1:0] low_word,
    output logic [WORD_WIDTH-1:0] high_word
);

    logic [WORD_WIDTH-1:0] cell_word [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_op_t              cell_op;
        logic [WORD_WIDTH-1:0] lower_word;
        logic [WORD_WIDTH-1:0] upper_word;

        always_comb
        begin
            unique case (op)
                CHAIN_SHIFT_UP:   cell_op = CELL_SHIFT_UP;
                CHAIN_SHIFT_DOWN: cell_op = CELL_SHIFT_DOWN;
                CHAIN_LOAD_AT:    cell_op = (load_index == IDX_W'(i)) ? CELL_LOAD : CELL_HOLD;
                default:          cell_op = CELL_HOLD;
            endcase
        end

        if (i == 0)
        begin : g_bottom
            assign lower_word = value;
        end
        else
        begin : g_mid_low
            assign lower_word = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_top
            assign upper_word = value;
        end
        else
        begin : g_mid_high
            assign upper_word = cell_word[i+1];
        end

        bdq_cell #(
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .from_lower (lower_word),
            .from_upper (upper_word),
            .load_word  (value),
            .word       (cell_word[i])
        );
    end

    assign low_word  = cell_word[0];
    assign high_word = cell_word[DEPTH-1];

endmodule

// ===== src/bounded_double_ended_queue.sv =====
// Bounded double-ended queue built from two shift-cell chains.
// The result of a command is strobed on done in the cycle after the transfer.
// Throughput: one command per cycle; busy stays low and each command updates the chains at most once.
// Reset clears the count and the reverse flag; stored words are not cleared.
// The receiver cannot stall, so every result is shown for exactly one cycle.
module bounded_double_ended_queue
    import bdq_pkg::*;
#(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned WORD_WIDTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  request,
    output logic      done,
    output out_item_t result
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rev_reg;
    logic             rev_next;
    logic             done_reg;
    err_t             err_reg;
    err_t             err_next;

    chain_op_t        low_op;
    chain_op_t        high_op;
    logic [IDX_W-1:0] low_load_index;
    logic [IDX_W-1:0] high_load_index;

    logic [WORD_WIDTH-1:0] push_word;
    logic [WORD_WIDTH-1:0] low_end_word;
    logic [WORD_WIDTH-1:0] high_end_word;
    logic [WORD_WIDTH-1:0] unused_low_top;
    logic [WORD_WIDTH-1:0] unused_high_bottom;
    logic [WORD_WIDTH-1:0] lo_word;
    logic [WORD_WIDTH-1:0] hi_word;

    logic is_empty_now;
    logic is_full_now;
    logic at_low;
    cmd_t cmd;

    assign busy      = 1'b0;
    assign push_word = request.value[WORD_WIDTH-1:0];
    assign cmd       = cmd_t'(request.cmd);

    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == CNT_W'(DEPTH));

    assign low_load_index  = count_reg[IDX_W-1:0];
    assign high_load_index = IDX_W'(CNT_W'(DEPTH - 1) - count_reg);

    always_comb
    begin
        count_next = count_reg;
        rev_next   = rev_reg;
        err_next   = ERR_OK;
        low_op     = CHAIN_HOLD;
        high_op    = CHAIN_HOLD;
        at_low     = 1'b0;
        if (start && !busy)
        begin
            unique case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    at_low = (cmd == CMD_PUSH_FRONT) != rev_reg;
                    if (is_full_now)
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        if (at_low)
                        begin
                            low_op  = CHAIN_SHIFT_UP;
                            high_op = CHAIN_LOAD_AT;
                        end
                        else
                        begin
                            low_op  = CHAIN_LOAD_AT;
                            high_op = CHAIN_SHIFT_DOWN;
                        end
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    at_low = (cmd == CMD_POP_FRONT) != rev_reg;
                    if (is_empty_now)
                    begin
                        err_next = ERR_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        if (at_low)
                        begin
                            low_op = CHAIN_SHIFT_DOWN;
                        end
                        else
                        begin
                            high_op = CHAIN_SHIFT_UP;
                        end
                    end
                end
                CMD_REVERSE:
                begin
                    if (is_empty_now)
                    begin
                        err_next = ERR_EMPTY;
                    end
                    else
                    begin
                        rev_next = !rev_reg;
                    end
                end
                default:
                begin
                    err_next = ERR_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rev_reg   <= 1'b0;
            done_reg  <= 1'b0;
            err_reg   <= ERR_OK;
        end
        else
        begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
            done_reg  <= start && !busy;
            err_reg   <= err_next;
        end
    end

    bdq_chain #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .IDX_W      (IDX_W)
    ) u_low_chain (
        .clk        (clk),
        .op         (low_op),
        .load_index (low_load_index),
        .value      (push_word),
        .low_word   (low_end_word),
        .high_word  (unused_low_top)
    );

    bdq_chain #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .IDX_W      (IDX_W)
    ) u_high_chain (
        .clk        (clk),
        .op         (high_op),
        .load_index (high_load_index),
        .value      (push_word),
        .low_word   (unused_high_bottom),
        .high_word  (high_end_word)
    );

    assign lo_word = is_empty_now ? '0 : low_end_word;
    assign hi_word = is_empty_now ? '0 : high_end_word;

    assign done               = done_reg;
    assign result.front_value = rev_reg ? WORD_BITS'(hi_word) : WORD_BITS'(lo_word);
    assign result.back_value  = rev_reg ? WORD_BITS'(lo_word) : WORD_BITS'(hi_word);
    assign result.entry_count = COUNT_BITS'(count_reg);
    assign result.is_empty    = is_empty_now;
    assign result.is_full     = is_full_now;
    assign result.error_code  = err_reg;

endmodule

// ===== src/bdq_checker.sv =====
// Port-level checker for the bounded double-ended queue, bound to the top level.
// Depends on bdq_pkg for the error codes and transfer structs.
module bdq_checker
    import bdq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input in_item_t  request,
    input logic      done,
    input out_item_t result
);

    logic unused_request;

    assign unused_request = ^request;

    a_done_follows_transfer : assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done
    ) else $error("A transfer was not followed by a result strobe.");

    a_no_spurious_done : assert property (
        @(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done
    ) else $error("A result strobe appeared without a transfer.");

    a_empty_matches_count : assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.entry_count == '0))
    ) else $error("The empty flag disagrees with the entry count.");

    a_empty_reads_zero : assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |-> (result.front_value == '0 && result.back_value == '0)
    ) else $error("An empty queue showed nonzero end words.");

    a_error_flags : assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> ((result.error_code != ERR_EMPTY || result.is_empty)
                  && (result.error_code != ERR_FULL || result.is_full))
    ) else $error("An error code disagrees with the empty or full flag.");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

// ===== verif/bounded_double_ended_queue_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bounded_double_ended_queue, built on bdq_pkg.
// A clocked driver feeds commands from a pending list while a monitor checks
// each strobed result against an in-bench deque predictor.
module bounded_double_ended_queue_tb;
    import bdq_pkg::*;

    localparam int unsigned QUEUE_DEPTH  = 16;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam logic [2:0]  CMD_SPARE_LO = 3'd6;
    localparam logic [2:0]  CMD_SPARE_HI = 3'd7;

    typedef struct {
        in_item_t    req;
        int unsigned idle_pct;
    } pending_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    in_item_t  request = '0;
    logic      done;
    out_item_t result;

    pending_t  pending_commands[$];
    out_item_t expected_results[$];
    int        failures = 0;

    logic [WORD_BITS-1:0]  model_words [QUEUE_DEPTH];
    logic [3:0]            model_head = '0;
    logic [COUNT_BITS-1:0] model_count = '0;
    logic                  model_flipped = 1'b0;

    bounded_double_ended_queue #(
        .DEPTH      (QUEUE_DEPTH),
        .WORD_WIDTH (WORD_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic out_item_t apply_command(in_item_t req);
        out_item_t            r;
        logic                 low;
        logic [3:0]           slot;
        logic [WORD_BITS-1:0] lo;
        logic [WORD_BITS-1:0] hi;
        r = '0;
        r.error_code = ERR_OK;
        lo = '0;
        hi = '0;
        case (req.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (model_count == QUEUE_DEPTH)
                begin
                    r.error_code = ERR_FULL;
                end
                else
                begin
                    low = (req.cmd == CMD_PUSH_FRONT) != model_flipped;
                    if (low)
                    begin
                        model_head = model_head - 4'd1;
                        model_words[model_head] = req.value;
                    end
                    else
                    begin
                        slot = model_head + model_count[3:0];
                        model_words[slot] = req.value;
                    end
                    model_count = model_count + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (model_count == 0)
                begin
                    r.error_code = ERR_EMPTY;
                end
                else
                begin
                    low = (req.cmd == CMD_POP_FRONT) != model_flipped;
                    if (low)
                    begin
                        model_head = model_head + 4'd1;
                    end
                    model_count = model_count - 1'b1;
                end
            end
            CMD_REVERSE:
            begin
                if (model_count == 0)
                begin
                    r.error_code = ERR_EMPTY;
                end
                else
                begin
                    model_flipped = ~model_flipped;
                end
            end
            default:
            begin
            end
        endcase
        if (model_count != 0)
        begin
            slot = model_head + model_count[3:0] - 4'd1;
            lo = model_words[model_head];
            hi = model_words[slot];
        end
        r.front_value = model_flipped ? hi : lo;
        r.back_value  = model_flipped ? lo : hi;
        r.entry_count = model_count;
        r.is_empty    = (model_count == 0);
        r.is_full     = (model_count == QUEUE_DEPTH);
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failures++;
        end
    endtask

    task automatic queue_command(logic [2:0] cmd, logic [WORD_BITS-1:0] value,
                                 int unsigned idle_pct);
        pending_t p;
        p.req.cmd   = cmd;
        p.req.value = value;
        p.idle_pct  = idle_pct;
        pending_commands.push_back(p);
    endtask

    function automatic logic [WORD_BITS-1:0] random_word();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [2:0] pick_command(int unsigned push_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        roll = $urandom_range(9);
        if (roll < 7)
            return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else if (roll == 7)
            return CMD_REVERSE;
        else if (roll == 8)
            return CMD_PEEK;
        return $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(apply_command(request));
            end
            if (!start || !busy)
            begin
                if (pending_commands.size() != 0 &&
                    $urandom_range(99) >= pending_commands[0].idle_pct)
                begin
                    request <= pending_commands[0].req;
                    start   <= 1'b1;
                    pending_commands.delete(0);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("front_value", want.front_value, result.front_value);
                check_field("back_value", want.back_value, result.back_value);
                check_field("entry_count", 64'(want.entry_count), 64'(result.entry_count));
                check_field("is_empty", 64'(want.is_empty), 64'(result.is_empty));
                check_field("is_full", 64'(want.is_full), 64'(result.is_full));
                check_field("error_code", 64'(want.error_code), 64'(result.error_code));
            end
        end
    end

    initial
    begin
        int unsigned idle_pct;
        int unsigned push_pct;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            model_words[i] = '0;

        // Empty deque: peek, pops, reverse, spare; then pushes past full.
        queue_command(CMD_PEEK, '1, 34);
        queue_command(CMD_POP_FRONT, '0, 34);
        queue_command(CMD_POP_BACK, '1, 34);
        queue_command(CMD_REVERSE, '0, 34);
        queue_command(CMD_SPARE_LO, '1, 34);
        queue_command(CMD_PUSH_FRONT, '0, 34);
        queue_command(CMD_PUSH_BACK, '1, 34);
        queue_command(CMD_PUSH_FRONT, 64'h8000_0000_0000_0001, 34);
        queue_command(CMD_PUSH_BACK, 64'h5555_5555_AAAA_AAAA, 34);
        queue_command(CMD_REVERSE, '0, 34);
        queue_command(CMD_POP_FRONT, '0, 34);
        queue_command(CMD_POP_BACK, '0, 34);
        for (int i = 0; i < QUEUE_DEPTH - 2; i++)
            queue_command(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, random_word(), 34);
        queue_command(CMD_PUSH_FRONT, '1, 34);
        queue_command(CMD_PUSH_BACK, '1, 34);
        queue_command(CMD_SPARE_HI, '0, 34);

        push_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i < RANDOM_ITEMS / 3)
                idle_pct = 34;
            else if (i < 2 * RANDOM_ITEMS / 3)
                idle_pct = 73;
            else
                idle_pct = 0;
            if (i % 30 == 0)
            begin
                case ($urandom_range(2))
                    0: push_pct = 75;
                    1: push_pct = 25;
                    default: push_pct = 50;
                endcase
            end
            queue_command(pick_command(push_pct), random_word(), idle_pct);
        end

        @(posedge rst_n);
        while (pending_commands.size() != 0 || start || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bdq_pkg.sv
src/bdq_cell.sv
src/bdq_chain.sv
src/bounded_double_ended_queue.sv
src/bdq_checker.sv
verif/bounded_double_ended_queue_tb.sv
